// ----- rtl/sorted_insert_priority_queue_macros.svh -----
// Assertion macros for the sorted insert priority queue.
// Needs clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at each rising edge, ignored while reset is asserted
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at each rising edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/spq_pkg.sv -----
// Shared types and constants for the sorted insert priority queue.
// No dependencies; used by every module of the block.
package spq_pkg;

  // Geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PRIO_W = 8;
  localparam int CHAR_W = 8;

  // Configuration port
  localparam int CAP_W        = 5;
  localparam int CAP_RESET    = 16;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;
  localparam logic [APB_ADDR_W-1:0] REG_CAPACITY = APB_ADDR_W'(0);

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [CHAR_W-1:0] chr;
  } entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic             enq;
    logic             deq;
    entry_t           new_entry;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

// ----- rtl/sorted_insert_priority_queue.sv -----
// Sorted insert priority queue: a chain of DEPTH cells kept in ascending order.
// The result is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle unless stalled; every cell compares to the new
// entry in parallel and shifts in the same cycle, so enqueue and dequeue cost alike.
// Reset: count cleared, capacity 16, output empty; cell contents undefined.
module sorted_insert_priority_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [spq_pkg::PRIO_W-1:0]      new_prio_i,
  input  logic [spq_pkg::CHAR_W-1:0]      new_char_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [spq_pkg::PRIO_W-1:0]      head_prio_o,
  output logic [spq_pkg::CHAR_W-1:0]      head_char_o,
  output logic [4:0]                      entry_count_o,
  output logic                            is_empty_o,
  output logic                            is_full_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spq_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [spq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [spq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import spq_pkg::*;
  `include "sorted_insert_priority_queue_macros.svh"

  logic [CNT_W-1:0]  eff_cap;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  entry_t            head_q, head_d;
  logic [CNT_W-1:0]  res_count_q;
  logic              res_empty_q, res_full_q;
  logic              in_acc;
  logic              is_enq;
  logic              full_now;
  logic              empty_now;
  logic              do_enq;
  logic              do_deq;
  cell_ctrl_t        ctrl;
  entry_t            cell_ent [DEPTH];
  logic              cell_ins [DEPTH];

  // Configuration register
  spq_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_cap_o (eff_cap)
  );

  // Request handshake: the output register frees as its result is taken
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Decode
  assign is_enq    = (func_i == FUNC_ENQ);
  assign full_now  = (count_q >= eff_cap);
  assign empty_now = (count_q == '0);
  assign do_enq    = in_acc & is_enq & ~full_now;
  assign do_deq    = in_acc & ~is_enq & ~empty_now;

  // Cell broadcast
  assign ctrl.enq            = do_enq;
  assign ctrl.deq            = do_deq;
  assign ctrl.new_entry.prio = new_prio_i;
  assign ctrl.new_entry.chr  = new_char_i;
  assign ctrl.count          = count_q;

  // Cell chain, head at index zero
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic   left_ins;
    entry_t left_ent;
    entry_t right_ent;

    if (k == 0) begin : g_first
      assign left_ins = 1'b0;
      assign left_ent = '0;
    end else begin : g_mid
      assign left_ins = cell_ins[k-1];
      assign left_ent = cell_ent[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_ent[k+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(k)),
      .ctrl_i      (ctrl),
      .left_ins_i  (left_ins),
      .left_ent_i  (left_ent),
      .right_ent_i (right_ent),
      .ins_o       (cell_ins[k]),
      .ent_o       (cell_ent[k])
    );
  end

  // Count update
  always_comb begin
    count_d = count_q;
    if (do_enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Result formation
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    status_d    = status_q;
    head_d      = head_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      if (is_enq) begin
        status_d = full_now ? ST_FULL : ST_DONE;
      end else begin
        status_d = empty_now ? ST_EMPTY : ST_DONE;
      end
      head_d = do_deq ? cell_ent[0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q    <= status_d;
      head_q      <= head_d;
      res_count_q <= count_d;
      res_empty_q <= (count_d == '0);
      res_full_q  <= (count_d >= eff_cap);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign head_prio_o   = head_q.prio;
  assign head_char_o   = head_q.chr;
  assign entry_count_o = 5'(res_count_q);
  assign is_empty_o    = res_empty_q;
  assign is_full_o     = res_full_q;

  // Checks
  `SPQ_ASSERT_ALWAYS(a_count_bound, (!rst_ni || count_q <= CNT_W'(DEPTH)), "count beyond depth")
  `SPQ_ASSERT(a_enq_grows, (do_enq |=> count_q == $past(count_q) + CNT_W'(1)), "enqueue lost")
  `SPQ_ASSERT(a_reject_holds, (in_acc && !do_enq && !do_deq |=> $stable(count_q)), "reject moved count")
  `SPQ_ASSERT(a_head_zero, (out_valid_q && (status_q != ST_DONE) |-> (head_q == '0)), "rejected head not zero")
  `SPQ_ASSERT(a_empty_flag, (out_valid_q |-> (res_empty_q == (res_count_q == '0))), "empty flag mismatch")

endmodule

// ----- rtl/spq_cfg.sv -----
// APB capacity register and effective capacity clamp.
// Depends on spq_pkg.
module spq_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spq_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [spq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [spq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [spq_pkg::CNT_W-1:0]       eff_cap_o
);
  import spq_pkg::*;

  logic [CAP_W-1:0] capacity_q;
  logic [CAP_W-1:0] capacity_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr == REG_CAPACITY);

  // Register write
  always_comb begin
    capacity_d = capacity_q;
    if (wr_en) begin
      capacity_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_W'(CAP_RESET);
    end else begin
      capacity_q <= capacity_d;
    end
  end

  // Readback
  assign prdata = (paddr == REG_CAPACITY) ? APB_DATA_W'(capacity_q) : '0;

  // Zero acts as one, anything beyond the depth acts as the depth
  always_comb begin
    if (capacity_q == '0) begin
      eff_cap_o = CNT_W'(1);
    end else if (int'(capacity_q) > DEPTH) begin
      eff_cap_o = CNT_W'(DEPTH);
    end else begin
      eff_cap_o = CNT_W'(capacity_q);
    end
  end

endmodule

// ----- rtl/spq_cell.sv -----
// One storage cell of the sorted chain: holds one entry, compares it to the
// incoming entry and shifts toward either neighbor. Depends on spq_pkg.
module spq_cell (
  input  logic                       clk_i,
  input  logic [spq_pkg::IDX_W-1:0]  idx_i,
  input  spq_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       left_ins_i,
  input  spq_pkg::entry_t            left_ent_i,
  input  spq_pkg::entry_t            right_ent_i,
  output logic                       ins_o,
  output spq_pkg::entry_t            ent_o
);
  import spq_pkg::*;

  entry_t ent_q;
  entry_t ent_d;
  logic   occupied;
  logic   first_free;

  assign occupied   = CNT_W'(idx_i) < ctrl_i.count;
  assign first_free = CNT_W'(idx_i) == ctrl_i.count;

  // Insert point at or before this cell: stored priority strictly greater,
  // or this is the first free cell
  assign ins_o = occupied ? (ent_q.prio > ctrl_i.new_entry.prio) : first_free;

  // Enqueue: cells past the insert point take the left neighbor, the insert
  // point takes the new entry. Dequeue: everything moves one to the left.
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.enq && ins_o) begin
      ent_d = left_ins_i ? left_ent_i : ctrl_i.new_entry;
    end else if (ctrl_i.deq) begin
      ent_d = right_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ----- tb/tb_sorted_insert_priority_queue.sv -----
// Self-checking testbench for the sorted insert priority queue.
// Depends on spq_pkg and the sorted_insert_priority_queue top level.
// A queue-based predictor checks every result; random idles cover both channels.
`timescale 1ns / 100ps

module tb_sorted_insert_priority_queue;
  import spq_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_PCT     = 20;
  localparam int PHASE_REQS   = 160;
  localparam int MAX_PRINTS   = 40;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef struct {
    func_e             op;
    logic [PRIO_W-1:0] prio;
    logic [CHAR_W-1:0] chr;
  } pq_request_t;

  typedef struct {
    status_e           status;
    logic [PRIO_W-1:0] prio;
    logic [CHAR_W-1:0] chr;
    logic [4:0]        count;
    logic              empty;
    logic              full;
  } pq_result_t;

  // Clock, reset and block inputs, all known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  func_i      = FUNC_ENQ;
  logic [PRIO_W-1:0]     new_prio_i  = '0;
  logic [CHAR_W-1:0]     new_char_i  = '0;
  logic                  out_stall_i = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [1:0]            status_o;
  logic [PRIO_W-1:0]     head_prio_o;
  logic [CHAR_W-1:0]     head_char_o;
  logic [4:0]            entry_count_o;
  logic                  is_empty_o;
  logic                  is_full_o;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Stimulus and prediction state
  pq_request_t pending_q[$];
  pq_result_t  expected_q[$];
  entry_t      sorted_q[$];
  pq_request_t drv_req;
  logic [4:0]  cap_cfg = 5'(CAP_RESET);
  bit          no_gaps = 1'b0;

  int fail_count   = 0;
  int req_count    = 0;
  int enq_count    = 0;
  int deq_count    = 0;
  int full_rejects = 0;
  int empty_rejects = 0;
  int cfg_writes   = 0;
  int peak_fill    = 0;

  sorted_insert_priority_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .new_prio_i   (new_prio_i),
    .new_char_i   (new_char_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .head_prio_o  (head_prio_o),
    .head_char_o  (head_char_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Capacity actually enforced: zero acts as one, above DEPTH clamps
  function automatic int usable_capacity();
    int c;
    c = cap_cfg;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  // Applies one request to the sorted copy and returns the result it should give
  function automatic pq_result_t apply_request(pq_request_t req);
    pq_result_t r;
    entry_t     head;
    int         pos;
    int         k;
    r.status = ST_DONE;
    r.prio   = '0;
    r.chr    = '0;
    if (req.op == FUNC_ENQ) begin
      if (sorted_q.size() >= usable_capacity()) begin
        r.status = ST_FULL;
      end else begin
        // insert ahead of the first strictly greater priority; ties stay FIFO
        pos = sorted_q.size();
        for (k = 0; k < sorted_q.size(); k++) begin
          if (sorted_q[k].prio > req.prio) begin
            pos = k;
            break;
          end
        end
        sorted_q.insert(pos, {req.prio, req.chr});
      end
    end else begin
      if (sorted_q.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        head   = sorted_q.pop_front();
        r.prio = head.prio;
        r.chr  = head.chr;
      end
    end
    r.count = 5'(sorted_q.size());
    r.empty = (sorted_q.size() == 0);
    r.full  = (sorted_q.size() >= usable_capacity());
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Request driver: holds the payload while stalled, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    pq_result_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        r = apply_request(drv_req);
        expected_q.push_back(r);
        req_count++;
        if (drv_req.op == FUNC_ENQ) enq_count++;
        else deq_count++;
        if (r.status == ST_FULL) full_rejects++;
        if (r.status == ST_EMPTY) empty_rejects++;
        if (sorted_q.size() > peak_fill) peak_fill = sorted_q.size();
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          drv_req    = pending_q.pop_front();
          in_valid_i <= 1'b1;
          func_i     <= drv_req.op;
          new_prio_i <= drv_req.prio;
          new_char_i <= drv_req.chr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares against the oldest prediction, stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    pq_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("status", status_o, want.status);
          check_field("head_prio", head_prio_o, want.prio);
          check_field("head_char", head_char_o, want.chr);
          check_field("entry_count", entry_count_o, want.count);
          check_field("is_empty", is_empty_o, want.empty);
          check_field("is_full", is_full_o, want.full);
        end
      end
      out_stall_i <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic push_req(input func_e op, input int prio, input int chr);
    pq_request_t req;
    req.op   = op;
    req.prio = PRIO_W'(prio);
    req.chr  = CHAR_W'(chr);
    pending_q.push_back(req);
  endtask

  // Waits until every request is out and every result has come back
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup then access; register is written when pready is seen high
  task automatic write_capacity(input int value);
    logic [APB_DATA_W-1:0] data;
    data      = $urandom();
    data[4:0] = 5'(value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CAPACITY;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_cfg = data[4:0];
    cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Bursts with an enqueue or dequeue bias so the queue both fills and drains
  task automatic gen_traffic(input int n);
    int left;
    int run;
    int enq_pct;
    int prio;
    left = n;
    while (left > 0) begin
      run = $urandom_range(40, 8);
      case ($urandom_range(2))
        0: enq_pct = 85;
        1: enq_pct = 50;
        default: enq_pct = 20;
      endcase
      repeat (run) begin
        if (left > 0) begin
          case ($urandom_range(3))
            0: prio = $urandom_range(7);            // dense, many ties
            1: prio = $urandom_range(1) ? 255 : 0;  // extremes
            default: prio = $urandom_range(255);
          endcase
          push_req(($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                   prio, $urandom_range(255));
          left--;
        end
      end
    end
  endtask

  initial begin
    int cap_plan[10];
    cap_plan = '{16, 3, 31, 1, 0, 9, 16, 17, 5, 16};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: empty dequeue, extremes, equal priorities kept in order
    push_req(FUNC_DEQ, 0, 0);
    push_req(FUNC_ENQ, 255, 8'h00);
    push_req(FUNC_ENQ, 0, 8'hFF);
    push_req(FUNC_ENQ, 8'h80, 8'hA5);
    push_req(FUNC_ENQ, 8'h80, 8'h5A);
    push_req(FUNC_ENQ, 8'h80, 8'h3C);
    push_req(FUNC_ENQ, 255, 8'hFF);
    repeat (7) push_req(FUNC_DEQ, 0, 0);
    wait_idle();

    // Small capacity: fill, then reject when full
    write_capacity(2);
    push_req(FUNC_ENQ, 8'h10, 8'h01);
    push_req(FUNC_ENQ, 8'h10, 8'h02);
    push_req(FUNC_ENQ, 8'h05, 8'h03);
    wait_idle();

    // Capacity lowered below the count: entries stay, still reads full
    write_capacity(1);
    push_req(FUNC_ENQ, 0, 0);
    push_req(FUNC_DEQ, 0, 0);
    push_req(FUNC_DEQ, 0, 0);
    wait_idle();

    // Zero capacity behaves as one
    write_capacity(0);
    push_req(FUNC_ENQ, 8'h7F, 8'h80);
    push_req(FUNC_ENQ, 8'h01, 8'h01);
    push_req(FUNC_DEQ, 0, 0);
    wait_idle();

    // Random phases; entries carry over so capacity often drops below the count
    foreach (cap_plan[i]) begin
      write_capacity(cap_plan[i]);
      no_gaps = (i == 6);
      gen_traffic(PHASE_REQS);
      wait_idle();
    end
    no_gaps = 1'b0;

    $display("Run covered %0d requests: %0d enqueues, %0d dequeues, %0d full and %0d empty rejects.",
             req_count, enq_count, deq_count, full_rejects, empty_rejects);
    $display("%0d capacity writes, peak occupancy %0d, %0d mismatches.",
             cfg_writes, peak_fill, fail_count);
    if (fail_count == 0) begin
      $display("tb_sorted_insert_priority_queue OK");
    end else begin
      $display("tb_sorted_insert_priority_queue NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d requests pending, %0d results outstanding.",
             pending_q.size(), expected_q.size());
    $display("tb_sorted_insert_priority_queue NOT OK");
    $finish;
  end

endmodule
